// File: rtl/core/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the secant root step engine
// Q32.32 item layouts, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int DATA_W  = 64;
  localparam int HALF_W  = DATA_W / 2;
  localparam int TOL_W   = DATA_W - 1;
  localparam int CNT_W   = $clog2(DATA_W);
  localparam int CFG_IDX_W = 2;

  // about 1e-6 in Q32.32
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4295);

  typedef struct packed {
    logic signed [DATA_W-1:0] x_point;
    logic signed [DATA_W-1:0] f_value;
  } srs_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] next_point;
    logic                     status;
    logic                     converged;
    logic signed [DATA_W-1:0] root;
  } srs_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_A     = 2'd0,
    CFG_START_B     = 2'd1,
    CFG_F_TOLERANCE = 2'd2,
    CFG_SLOPE_FLOOR = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CALC,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHK,
    MD_DIV
  } md_state_t;

endpackage

// File: rtl/core/srs_muldiv.sv
// ----------------------------------------------------------------------------
// srs_muldiv: shared multiply then divide unit
// Forms a*b with one half-width multiplier over four partial products, then
// divides the double-width product by d one quotient bit a cycle. Saturates
// to all ones on a zero divisor or quotient overflow.
// ----------------------------------------------------------------------------
module srs_muldiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [srs_pkg::DATA_W-1:0]  mul_a,
  input  logic [srs_pkg::DATA_W-1:0]  mul_b,
  input  logic [srs_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [srs_pkg::DATA_W-1:0]  quotient
);

  localparam int W = srs_pkg::DATA_W;
  localparam int H = srs_pkg::HALF_W;

  srs_pkg::md_state_t             state_r, state_nxt;
  logic [srs_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [W-1:0]                   a_r, a_nxt, b_r, b_nxt, d_r, d_nxt;
  logic [W-1:0]                   prod_r, prod_nxt;
  logic [1:0]                     sh_r, sh_nxt;
  logic [2*W-1:0]                 acc_r, acc_nxt;
  logic                           done_r, done_nxt;

  logic [H-1:0]   half_a, half_b;
  logic [2*W-1:0] addend;
  logic           carry, ge;
  logic [W-1:0]   trial, rem_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srs_pkg::MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    sh_r   <= sh_nxt;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    prod_nxt  = prod_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;

    half_a = cnt_r[1] ? a_r[W-1:H] : a_r[H-1:0];
    half_b = cnt_r[0] ? b_r[W-1:H] : b_r[H-1:0];
    addend = {{W{1'b0}}, prod_r} << (H * sh_r);

    carry = acc_r[2*W-1];
    trial = {acc_r[2*W-2:W], acc_r[W-1]};
    ge    = carry || (trial >= d_r);
    rem_n = ge ? (trial - d_r) : trial;

    unique case (state_r)
      srs_pkg::MD_IDLE: begin
        if (start) begin
          a_nxt     = mul_a;
          b_nxt     = mul_b;
          d_nxt     = divisor;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = srs_pkg::MD_MUL;
        end
      end
      srs_pkg::MD_MUL: begin
        prod_nxt = W'(half_a) * W'(half_b);
        sh_nxt   = 2'(cnt_r[1]) + 2'(cnt_r[0]);
        if (cnt_r != '0) begin
          acc_nxt = acc_r + addend;
        end
        if (cnt_r[2]) begin
          cnt_nxt   = '0;
          state_nxt = srs_pkg::MD_CHK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      srs_pkg::MD_CHK: begin
        if ((d_r == '0) || (acc_r[2*W-1:W] >= d_r)) begin
          acc_nxt[W-1:0] = '1;
          done_nxt       = 1'b1;
          state_nxt      = srs_pkg::MD_IDLE;
        end else begin
          state_nxt = srs_pkg::MD_DIV;
        end
      end
      srs_pkg::MD_DIV: begin
        acc_nxt = {rem_n, acc_r[W-2:0], ge};
        if (cnt_r == srs_pkg::CNT_W'(W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = srs_pkg::MD_IDLE;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      default: state_nxt = srs_pkg::MD_IDLE;
    endcase
  end

  assign done     = done_r;
  assign quotient = acc_r[W-1:0];

endmodule

// File: rtl/core/secant_root_step.sv
// ----------------------------------------------------------------------------
// secant_root_step: secant root-finding step engine, signed Q32.32
// Takes one evaluated point (x, f(x)) per item and returns the next abscissa,
// flat-slope status and convergence with the recorded root.
//
//   channel | dir | handshake              | payload
//   in_     | in  | in_valid / in_ready    | in_data   (srs_in_t)
//   out_    | out | out_valid / out_ready  | out_data  (srs_out_t)
//   cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A full secant step is paced by the bit-serial divide in srs_muldiv, after
// its multiply phase and sequencing. First item and flat-slope items skip
// the multiply and divide; a zero divisor or quotient overflow skips only
// the divide. One item is in flight at a time.
// Synchronous active-low reset. A waiting result sits in the output register;
// a finished item stalls in S_DONE only while that register is still full.
// ----------------------------------------------------------------------------
module secant_root_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  srs_pkg::srs_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output srs_pkg::srs_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  srs_pkg::cfg_idx_t               cfg_index,
  input  logic [srs_pkg::DATA_W-1:0]      cfg_data
);

  localparam int W = srs_pkg::DATA_W;

  srs_pkg::seq_state_t        state_r, state_nxt;
  srs_pkg::phase_t            phase_r, phase_nxt;
  logic [W-1:0]               last_x_r, last_x_nxt, last_fx_r, last_fx_nxt;
  logic [W-1:0]               proposed_r, proposed_nxt, root_found_r, root_found_nxt;
  logic                       status_r, status_nxt, neg_r, neg_nxt;
  logic [W-1:0]               start_b_r;
  logic [srs_pkg::TOL_W-1:0]  tol_r, floor_r;
  logic                       out_valid_r, out_valid_nxt;
  srs_pkg::srs_out_t          out_data_r, out_data_nxt;
  logic [W-1:0]               x_r, f_r;

  logic                       md_start, md_done;
  logic [W-1:0]               md_q;
  logic signed [W:0]          df_s, dx_s;
  logic [W-1:0]               df_mag, dx_mag, pm_mag, am_mag, u_off, u_diff;
  logic [W:0]                 u_sum;
  logic                       conv;

  srs_muldiv u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (md_start),
    .mul_a    (pm_mag),
    .mul_b    (dx_mag),
    .divisor  (df_mag),
    .done     (md_done),
    .quotient (md_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= srs_pkg::S_IDLE;
      phase_r      <= srs_pkg::PH_INIT;
      last_x_r     <= '0;
      last_fx_r    <= '0;
      proposed_r   <= '0;
      root_found_r <= '0;
      status_r     <= 1'b0;
      neg_r        <= 1'b0;
      start_b_r    <= '0;
      tol_r        <= srs_pkg::TOL_RESET;
      floor_r      <= srs_pkg::TOL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      last_x_r     <= last_x_nxt;
      last_fx_r    <= last_fx_nxt;
      proposed_r   <= proposed_nxt;
      root_found_r <= root_found_nxt;
      status_r     <= status_nxt;
      neg_r        <= neg_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          srs_pkg::CFG_START_A:     ;  // start point is driven by the caller
          srs_pkg::CFG_START_B:     start_b_r <= cfg_data;
          srs_pkg::CFG_F_TOLERANCE: tol_r     <= cfg_data[srs_pkg::TOL_W-1:0];
          srs_pkg::CFG_SLOPE_FLOOR: floor_r   <= cfg_data[srs_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_valid && in_ready) begin
      x_r <= in_data.x_point;
      f_r <= in_data.f_value;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    last_x_nxt     = last_x_r;
    last_fx_nxt    = last_fx_r;
    proposed_nxt   = proposed_r;
    root_found_nxt = root_found_r;
    status_nxt     = status_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    md_start       = 1'b0;
    in_ready       = 1'b0;

    df_s   = {f_r[W-1], f_r} - {last_fx_r[W-1], last_fx_r};
    dx_s   = {x_r[W-1], x_r} - {last_x_r[W-1], last_x_r};
    df_mag = df_s[W] ? W'(-df_s) : df_s[W-1:0];
    dx_mag = dx_s[W] ? W'(-dx_s) : dx_s[W-1:0];
    pm_mag = last_fx_r[W-1] ? (~last_fx_r + 1'b1) : last_fx_r;
    am_mag = pm_mag;
    conv   = am_mag < {1'b0, tol_r};

    u_off  = {~last_x_r[W-1], last_x_r[W-2:0]};
    u_sum  = {1'b0, u_off} + {1'b0, md_q};
    u_diff = u_off - md_q;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      srs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = srs_pkg::S_PREP;
        end
      end
      srs_pkg::S_PREP: begin
        status_nxt = 1'b0;
        if (phase_r == srs_pkg::PH_INIT) begin
          last_x_nxt   = x_r;
          last_fx_nxt  = f_r;
          proposed_nxt = start_b_r;
          phase_nxt    = srs_pkg::PH_RUN;
          state_nxt    = srs_pkg::S_DONE;
        end else if (df_mag < {1'b0, floor_r}) begin
          status_nxt = 1'b1;
          state_nxt  = srs_pkg::S_DONE;
        end else begin
          neg_nxt   = (last_fx_r[W-1] != dx_s[W]) != df_s[W];
          md_start  = 1'b1;
          state_nxt = srs_pkg::S_CALC;
        end
      end
      srs_pkg::S_CALC: begin
        if (md_done) begin
          if (!neg_r) begin
            proposed_nxt = (md_q > u_off) ? {1'b1, {(W-1){1'b0}}}
                                          : {~u_diff[W-1], u_diff[W-2:0]};
          end else begin
            proposed_nxt = u_sum[W] ? {1'b0, {(W-1){1'b1}}}
                                    : {~u_sum[W-1], u_sum[W-2:0]};
          end
          last_x_nxt  = x_r;
          last_fx_nxt = f_r;
          state_nxt   = srs_pkg::S_DONE;
        end
      end
      srs_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.next_point = proposed_r;
          out_data_nxt.status     = status_r;
          out_data_nxt.converged  = conv;
          out_data_nxt.root       = conv ? last_x_r : '0;
          if (conv) begin
            root_found_nxt = last_x_r;
            phase_nxt      = srs_pkg::PH_DONE;
          end
          state_nxt = srs_pkg::S_IDLE;
        end
      end
      default: state_nxt = srs_pkg::S_IDLE;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: test/secant_root_step_test.sv
// ----------------------------------------------------------------------------
// secant_root_step_test: self-checking bench for the secant root step engine
// A directed table covers start-up, flat slopes, saturation and convergence
// under extreme bounds; random phases then follow the block's own proposals
// on linear functions, mixed with noise, near-flat and corner items. Every
// result is checked against an in-bench secant predictor or a fixed table
// value, with both channels idling and stalling at random.
// ----------------------------------------------------------------------------
module secant_root_step_test;

  localparam int DATA_W = srs_pkg::DATA_W;
  localparam int HALF_W = srs_pkg::HALF_W;
  localparam int TOL_W  = srs_pkg::TOL_W;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MIN_Q = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MAX_Q = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    bit                  is_reg;
    srs_pkg::cfg_idx_t   idx;
    logic [DATA_W-1:0]   wdata;
    srs_pkg::srs_in_t    pt;
    bit                  typed;
    srs_pkg::srs_out_t   want;
  } row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  srs_pkg::srs_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  srs_pkg::srs_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  srs_pkg::cfg_idx_t cfg_index = srs_pkg::CFG_START_A;
  logic [DATA_W-1:0] cfg_data  = '0;

  // predictor state and register copies
  srs_pkg::phase_t          walk_phase = srs_pkg::PH_INIT;
  logic signed [DATA_W-1:0] prev_x     = '0;
  logic signed [DATA_W-1:0] prev_fx    = '0;
  logic signed [DATA_W-1:0] guess_x    = '0;
  logic signed [DATA_W-1:0] root_rec   = '0;
  logic [DATA_W-1:0]        reg_start_a = '0;
  logic [DATA_W-1:0]        reg_start_b = '0;
  logic [TOL_W-1:0]         reg_f_tol   = srs_pkg::TOL_RESET;
  logic [TOL_W-1:0]         reg_floor   = srs_pkg::TOL_RESET;

  srs_pkg::srs_out_t steps_due[$];
  srs_pkg::srs_out_t oldest;
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_left     = 0;
  int unsigned tick           = 0;
  logic signed [DATA_W-1:0] aim = '0;
  int unsigned lean = 0;
  bit          flip = 1'b0;
  row_t        plan[$];

  secant_root_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic signed [DATA_W-1:0] q(int n);
    return 64'(n) <<< HALF_W;
  endfunction

  function automatic srs_pkg::srs_out_t secant_update(srs_pkg::srs_in_t pt);
    srs_pkg::srs_out_t r;
    logic [DATA_W-1:0] df, dx, pm, u, qm;
    logic [127:0]      prod;
    logic              ndf, ndx, nf, np;
    r = '0;
    if (walk_phase == srs_pkg::PH_INIT) begin
      prev_x     = pt.x_point;
      prev_fx    = pt.f_value;
      guess_x    = reg_start_b;
      walk_phase = srs_pkg::PH_RUN;
    end else begin
      ndf = pt.f_value < prev_fx;
      df  = ndf ? prev_fx - pt.f_value : pt.f_value - prev_fx;
      if (df < {1'b0, reg_floor}) begin
        r.status = 1'b1;
      end else begin
        ndx  = pt.x_point < prev_x;
        dx   = ndx ? prev_x - pt.x_point : pt.x_point - prev_x;
        nf   = prev_fx[DATA_W-1];
        pm   = nf ? -prev_fx : prev_fx;
        prod = 128'(pm) * 128'(dx);
        // saturate on a zero or too small divisor
        if (df == '0 || prod[127:64] >= df) qm = '1;
        else qm = 64'(prod / 128'(df));
        np = nf ^ ndx ^ ndf;
        u  = prev_x ^ SIGN_BIT;
        if (!np) u = (qm > u) ? '0 : u - qm;
        else u = (qm > ~u) ? '1 : u + qm;
        guess_x = u ^ SIGN_BIT;
        prev_x  = pt.x_point;
        prev_fx = pt.f_value;
      end
    end
    pm = prev_fx[DATA_W-1] ? -prev_fx : prev_fx;
    if (pm < {1'b0, reg_f_tol}) begin
      root_rec    = prev_x;
      walk_phase  = srs_pkg::PH_DONE;
      r.converged = 1'b1;
      r.root      = root_rec;
    end
    r.next_point = guess_x;
    return r;
  endfunction

  function automatic row_t reg_row(srs_pkg::cfg_idx_t idx, logic [DATA_W-1:0] d);
    row_t r;
    r        = '{idx: srs_pkg::CFG_START_A, default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.wdata  = d;
    return r;
  endfunction

  function automatic row_t pt_row(logic signed [DATA_W-1:0] x,
                                  logic signed [DATA_W-1:0] f);
    row_t r;
    r            = '{idx: srs_pkg::CFG_START_A, default: '0};
    r.pt.x_point = x;
    r.pt.f_value = f;
    return r;
  endfunction

  function automatic row_t fixed_row(logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] f,
                                     logic signed [DATA_W-1:0] nxt, logic st);
    row_t r;
    r                 = pt_row(x, f);
    r.typed           = 1'b1;
    r.want.next_point = nxt;
    r.want.status     = st;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_bound();
    logic [DATA_W-1:0] b;
    case ($urandom_range(0, 5))
      0:       b = '0;
      1:       b = {1'b0, {TOL_W{1'b1}}};
      2, 3:    b = {1'b0, srs_pkg::TOL_RESET};
      default: b = rand64() >> $urandom_range(16, 60);
    endcase
    b[DATA_W-1] = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic srs_pkg::srs_in_t make_item();
    srs_pkg::srs_in_t         it;
    int unsigned              pick;
    int unsigned              w;
    logic signed [DATA_W-1:0] corners[5];
    corners = '{MIN_Q, MAX_Q, '0, '1, 64'sd1};
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) aim = $signed(rand64()) >>> $urandom_range(12, 40);
    if (pick < 60) begin
      // follow the block's own proposal on a linear function
      if (walk_phase == srs_pkg::PH_INIT || $urandom_range(0, 9) == 0)
        it.x_point = $signed(rand64()) >>> $urandom_range(16, 40);
      else
        it.x_point = guess_x;
      it.f_value = (it.x_point - aim) >>> lean;
      if ($urandom_range(0, 3) == 0) it.f_value += 64'($urandom_range(0, 6)) - 64'd3;
      if (flip) it.f_value = -it.f_value;
    end else if (pick < 75) begin
      it.x_point = $signed(rand64()) >>> $urandom_range(20, 40);
      it.f_value = $signed(rand64()) >>> $urandom_range(20, 40);
    end else if (pick < 85) begin
      it.x_point = rand64();
      it.f_value = rand64();
    end else if (pick < 95) begin
      // near-flat slope around the floor
      case ($urandom_range(0, 2))
        0:       w = 0;
        1:       w = 32'(srs_pkg::TOL_RESET);
        default: w = 1 << 20;
      endcase
      it.x_point = $signed(rand64()) >>> $urandom_range(16, 40);
      it.f_value = prev_fx + 64'($urandom_range(0, 2 * w)) - 64'(w);
    end else begin
      it.x_point = corners[$urandom_range(0, 4)];
      it.f_value = corners[$urandom_range(0, 4)];
    end
    return it;
  endfunction

  task automatic offer_item(srs_pkg::srs_in_t it, bit typed, srs_pkg::srs_out_t want);
    srs_pkg::srs_out_t got;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    got = secant_update(it);
    steps_due.push_back(typed ? want : got);
    if (burst_left != 0) begin
      burst_left--;
    end else if (tick[11:9] != 3'b101) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(40, 100)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic write_reg(srs_pkg::cfg_idx_t idx, logic [DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      srs_pkg::CFG_START_A:     reg_start_a = d;
      srs_pkg::CFG_START_B:     reg_start_b = d;
      srs_pkg::CFG_F_TOLERANCE: reg_f_tol   = d[TOL_W-1:0];
      srs_pkg::CFG_SLOPE_FLOOR: reg_floor   = d[TOL_W-1:0];
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (steps_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    tick <= tick + 1;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (tick[11:9] == 3'b101) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          out_ready  <= 1'b0;
          stall_left <= $urandom_range(1, 40);
        end
        1, 2:    out_ready <= 1'b0;
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (steps_due.size() == 0) begin
        $error("unexpected item: next_point %h", out_data.next_point);
        mismatch_count++;
      end else begin
        oldest = steps_due.pop_front();
        if (out_data.next_point !== oldest.next_point) begin
          $error("next_point: expected %h, got %h", oldest.next_point, out_data.next_point);
          mismatch_count++;
        end
        if (out_data.status !== oldest.status) begin
          $error("status: expected %b, got %b", oldest.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.converged !== oldest.converged) begin
          $error("converged: expected %b, got %b", oldest.converged, out_data.converged);
          mismatch_count++;
        end
        if (out_data.root !== oldest.root) begin
          $error("root: expected %h, got %h", oldest.root, out_data.root);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 20);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    plan.push_back(reg_row(srs_pkg::CFG_START_A, q(7)));
    plan.push_back(reg_row(srs_pkg::CFG_START_B, q(5)));
    plan.push_back(reg_row(srs_pkg::CFG_F_TOLERANCE, {1'b0, srs_pkg::TOL_RESET}));
    plan.push_back(reg_row(srs_pkg::CFG_SLOPE_FLOOR, {1'b0, srs_pkg::TOL_RESET}));
    plan.push_back(fixed_row(q(2), q(3), q(5), 1'b0));        // first point: start_b
    plan.push_back(fixed_row(q(5), q(3), q(5), 1'b1));        // flat slope
    plan.push_back(pt_row(q(5), q(-1)));
    plan.push_back(pt_row(q(4) + 64'sh4000_0000, '0));        // exact root
    plan.push_back(pt_row(q(3), 64'sd4294));                  // just under the floor
    plan.push_back(pt_row(MAX_Q, MAX_Q));
    plan.push_back(pt_row(MIN_Q, MIN_Q));
    plan.push_back(pt_row(MIN_Q, MAX_Q));
    plan.push_back(pt_row(MAX_Q, MIN_Q));
    plan.push_back(pt_row('0, '0));
    plan.push_back(pt_row('1, 64'sd1));
    plan.push_back(reg_row(srs_pkg::CFG_F_TOLERANCE, '0));
    plan.push_back(reg_row(srs_pkg::CFG_SLOPE_FLOOR, SIGN_BIT));  // top bit dropped: floor 0
    plan.push_back(pt_row(q(1), q(2)));
    plan.push_back(fixed_row(q(3), q(2), MIN_Q, 1'b0));       // zero slope, saturates low
    plan.push_back(fixed_row(q(1), q(2), MAX_Q, 1'b0));       // zero slope, saturates high
    plan.push_back(pt_row(q(1), '0));
    plan.push_back(reg_row(srs_pkg::CFG_F_TOLERANCE, '1));
    plan.push_back(reg_row(srs_pkg::CFG_SLOPE_FLOOR, '1));
    plan.push_back(pt_row(q(9), q(1)));
    plan.push_back(pt_row(q(9), MIN_Q));
    plan.push_back(pt_row(q(2), MAX_Q));
    plan.push_back(pt_row(q(2), q(-7)));
    plan.push_back(reg_row(srs_pkg::CFG_START_A, MIN_Q));
    plan.push_back(reg_row(srs_pkg::CFG_START_B, MAX_Q));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) settle();
        write_reg(plan[i].idx, plan[i].wdata);
        if (i + 1 == plan.size() || !plan[i+1].is_reg) cfg_valid <= 1'b0;
      end else begin
        offer_item(plan[i].pt, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < 7; p++) begin
      settle();
      write_reg(srs_pkg::CFG_START_A, rand64());
      write_reg(srs_pkg::CFG_START_B, rand64());
      write_reg(srs_pkg::CFG_F_TOLERANCE, pick_bound());
      write_reg(srs_pkg::CFG_SLOPE_FLOOR, pick_bound());
      cfg_valid <= 1'b0;
      aim  = $signed(rand64()) >>> $urandom_range(12, 40);
      lean = $urandom_range(0, 3);
      flip = 1'($urandom_range(0, 1));
      repeat (120) offer_item(make_item(), 1'b0, '0);
    end

    settle();
    repeat (150) @(posedge clk);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
